[design/rotation_matrix_to_quaternion_unit_defines.svh]
// Assertion helpers shared by the rotation matrix to quaternion unit.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define R2Q_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define R2Q_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/r2q_pkg.sv]
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared types and constants of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package r2q_pkg;

  localparam int ELEM_W  = 16;   // matrix entry width
  localparam int COMP_W  = 16;   // quaternion component width
  localparam int TRACE_W = 18;   // trace combination width
  localparam int PAIR_W  = 17;   // off-diagonal sum or difference width
  localparam int IDX_W   = 2;
  localparam int N_ELEM  = 9;
  localparam int N_LANE  = 3;    // components produced by division
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [IDX_W-1:0] {
    PART_W = 2'd0,
    PART_X = 2'd1,
    PART_Y = 2'd2,
    PART_Z = 2'd3
  } part_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/r2q_front.sv]
// ----------------------------------------------------------------------------
// r2q_front
// Forms the four trace combinations, picks the largest, builds the radicand
// and routes the three off-diagonal pairs to the non-chosen components.
// ----------------------------------------------------------------------------
module r2q_front #(
  parameter int FRAC_BITS = 14,
  parameter int RAD_W     = 18
) (
  input  logic [r2q_pkg::N_ELEM*r2q_pkg::ELEM_W-1:0] mat,
  output logic [RAD_W-1:0]                         rad,
  output logic signed [r2q_pkg::PAIR_W-1:0]        pair0,
  output logic signed [r2q_pkg::PAIR_W-1:0]        pair1,
  output logic signed [r2q_pkg::PAIR_W-1:0]        pair2,
  output r2q_pkg::part_t                           part
);
  import r2q_pkg::*;

  localparam int RS_W = RAD_W + 1;

  logic signed [ELEM_W-1:0]  m [N_ELEM];
  logic signed [TRACE_W-1:0] tw, tx, ty, tz, best;
  logic signed [RS_W-1:0]    rad_s;
  logic signed [PAIR_W-1:0]  pwx, pwy, pwz, pxy, pxz, pyz;

  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      m[i] = mat[i*ELEM_W +: ELEM_W];
    end
  end

  // m[0] m11, m[1] m12, m[2] m13, m[3] m21 ... m[8] m33
  assign tw = TRACE_W'(m[0]) + TRACE_W'(m[4]) + TRACE_W'(m[8]);
  assign tx = TRACE_W'(m[0]) - TRACE_W'(m[4]) - TRACE_W'(m[8]);
  assign ty = TRACE_W'(m[4]) - TRACE_W'(m[0]) - TRACE_W'(m[8]);
  assign tz = TRACE_W'(m[8]) - TRACE_W'(m[0]) - TRACE_W'(m[4]);

  assign pwx = PAIR_W'(m[5]) - PAIR_W'(m[7]);
  assign pwy = PAIR_W'(m[6]) - PAIR_W'(m[2]);
  assign pwz = PAIR_W'(m[1]) - PAIR_W'(m[3]);
  assign pxy = PAIR_W'(m[1]) + PAIR_W'(m[3]);
  assign pxz = PAIR_W'(m[6]) + PAIR_W'(m[2]);
  assign pyz = PAIR_W'(m[5]) + PAIR_W'(m[7]);

  // strict compare keeps the earlier component on a tie
  always_comb begin
    best = tw;
    part = PART_W;
    if (tx > best) begin
      best = tx;
      part = PART_X;
    end
    if (ty > best) begin
      best = ty;
      part = PART_Y;
    end
    if (tz > best) begin
      best = tz;
      part = PART_Z;
    end
  end

  assign rad_s = RS_W'(best) + (RS_W'(1) << FRAC_BITS);
  assign rad   = rad_s[RS_W-1] ? '0 : rad_s[RAD_W-1:0];

  always_comb begin
    unique case (part)
      PART_W: begin
        pair0 = pwx; pair1 = pwy; pair2 = pwz;
      end
      PART_X: begin
        pair0 = pwx; pair1 = pxy; pair2 = pxz;
      end
      PART_Y: begin
        pair0 = pwy; pair1 = pxy; pair2 = pyz;
      end
      default: begin
        pair0 = pwz; pair1 = pxz; pair2 = pyz;
      end
    endcase
  end

endmodule

[design/r2q_queue.sv]
// ----------------------------------------------------------------------------
// r2q_queue
// Short queue between the classifying front and the arithmetic back end.
// ----------------------------------------------------------------------------
module r2q_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output r2q_pkg::q_status_t status
);
  import r2q_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata        = store[rd_ptr];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  `include "rotation_matrix_to_quaternion_unit_defines.svh"

  `R2Q_NEVER(a_no_overflow, push && status.full && !pop, "queue written while full")
  `R2Q_NEVER(a_no_underflow, pop && status.empty, "queue read while empty")
  `R2Q_ASSERT(a_count_range, count <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

[design/r2q_sqrt.sv]
// ----------------------------------------------------------------------------
// r2q_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// payload carried alongside.
// ----------------------------------------------------------------------------
module r2q_sqrt #(
  parameter int ROOT_W = 16,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int X_W = 2 * ROOT_W;

  logic [X_W-1:0]    rem  [ROOT_W+1];
  logic [ROOT_W-1:0] acc  [ROOT_W+1];
  logic [SIDE_W-1:0] side [ROOT_W+1];
  logic              vld  [ROOT_W+1];

  assign rem[0]  = radicand;
  assign acc[0]  = '0;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic [X_W-1:0] trial;
    assign trial = (X_W'(acc[s]) << (K + 1)) | (X_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s+1] <= side[s];
        if (rem[s] >= trial) begin
          rem[s+1] <= rem[s] - trial;
          acc[s+1] <= acc[s] | (ROOT_W'(1) << K);
        end else begin
          rem[s+1] <= rem[s];
          acc[s+1] <= acc[s];
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = acc[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

[design/r2q_div.sv]
// ----------------------------------------------------------------------------
// r2q_div
// Three-lane pipelined divider: pair * 2^FRAC_BITS / (4 * root), truncated
// toward zero and saturated to the component range, one quotient bit a stage.
// ----------------------------------------------------------------------------
module r2q_div #(
  parameter int FRAC_BITS = 14,
  parameter int ROOT_W    = 16,
  parameter int SIDE_W    = 8
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           en,
  input  logic                                           in_valid,
  input  logic [ROOT_W-1:0]                              root,
  input  logic [r2q_pkg::N_LANE*r2q_pkg::PAIR_W-1:0]     pairs,
  input  logic [SIDE_W-1:0]                              in_side,
  output logic                                           out_valid,
  output logic [r2q_pkg::N_LANE*r2q_pkg::COMP_W-1:0]     quots,
  output logic [SIDE_W-1:0]                              out_side
);
  import r2q_pkg::*;

  localparam int QB    = COMP_W - 1;
  localparam int D_W   = ROOT_W + 2;
  localparam int N_W   = PAIR_W + FRAC_BITS;
  localparam int CW    = ((N_W > D_W + QB) ? N_W : D_W + QB) + 1;
  localparam int LAST  = QB + 1;

  logic [CW-1:0]     rem  [N_LANE][LAST+1];
  logic [QB-1:0]     quo  [N_LANE][LAST+1];
  logic              neg  [N_LANE][LAST+1];
  logic              zero [N_LANE][LAST+1];
  logic              ovf  [N_LANE][LAST+1];
  logic [CW-1:0]     dv   [LAST+1];
  logic [SIDE_W-1:0] side [LAST+1];
  logic              vld  [LAST+1];
  logic [COMP_W-1:0] res  [N_LANE];

  // stage 0: magnitudes and scaled numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]   <= CW'(root) << 2;
      side[0] <= in_side;
    end
  end

  for (genvar l = 0; l < N_LANE; l++) begin : g_lane
    logic signed [PAIR_W-1:0] p;
    logic [PAIR_W-1:0]        mag;
    assign p   = pairs[l*PAIR_W +: PAIR_W];
    assign mag = p[PAIR_W-1] ? PAIR_W'(-p) : PAIR_W'(p);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[l][0]  <= CW'(mag) << FRAC_BITS;
        quo[l][0]  <= '0;
        neg[l][0]  <= p[PAIR_W-1];
        zero[l][0] <= (p == '0);
        ovf[l][0]  <= 1'b0;
      end
    end

    for (genvar s = 1; s <= LAST; s++) begin : g_stage
      always_ff @(posedge clk) begin
        if (en) begin
          neg[l][s]  <= neg[l][s-1];
          zero[l][s] <= zero[l][s-1];
          if (s == 1) begin
            // quotient of 2^15 or more (or zero divisor) saturates
            ovf[l][s] <= (rem[l][s-1] >= (dv[s-1] << QB));
            rem[l][s] <= rem[l][s-1];
            quo[l][s] <= quo[l][s-1];
          end else begin
            ovf[l][s] <= ovf[l][s-1];
            if (!ovf[l][s-1] && rem[l][s-1] >= (dv[s-1] << (LAST - s))) begin
              rem[l][s] <= rem[l][s-1] - (dv[s-1] << (LAST - s));
              quo[l][s] <= quo[l][s-1] | (QB'(1) << (LAST - s));
            end else begin
              rem[l][s] <= rem[l][s-1];
              quo[l][s] <= quo[l][s-1];
            end
          end
        end
      end
    end

    always_comb begin
      if (zero[l][LAST]) begin
        res[l] = '0;
      end else if (ovf[l][LAST]) begin
        res[l] = neg[l][LAST] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else if (neg[l][LAST]) begin
        res[l] = -{1'b0, quo[l][LAST]};
      end else begin
        res[l] = {1'b0, quo[l][LAST]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quots[l*COMP_W +: COMP_W] <= res[l];
      end
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[s]   <= dv[s-1];
        side[s] <= side[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side[LAST];
    end
  end

endmodule

[design/rotation_matrix_to_quaternion_unit.sv]
// Pipeline: ROOT_W square-root stages + 18 divider stages (input register, overflow
//   check, 15 quotient bits, output register); ROOT_W = (max(17, FRAC_BITS) + FRAC_BITS)
//   / 2 rounded down, 15 at FRAC_BITS = 14.
// Throughput: one matrix per cycle; the square root and the three dividers are
//   fully pipelined, one bit per stage, and advance whenever the output is free.
// Reset: rst clears the queue and every pipeline valid bit; data registers keep.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a stream of Q1.14 rotation matrices into unit quaternions.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m_r1c1, m_r1c2, m_r1c3, m_r2c1, m_r2c2, m_r2c3, m_r3c1, m_r3c2, m_r3c3
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [63:0]  m_axis_tdata,
  // largest_part
  output logic [1:0]   m_axis_tuser
);
  import r2q_pkg::*;

  localparam int RAD_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int X_W    = RAD_W + FRAC_BITS - 2;
  localparam int ROOT_W = (X_W + 1) / 2;
  localparam int BQ_W   = (ROOT_W > COMP_W) ? ROOT_W : COMP_W;
  localparam int PAIRS_W = N_LANE * PAIR_W;
  localparam int ENTRY_W = RAD_W + PAIRS_W + IDX_W;
  localparam int SQ_SIDE_W = PAIRS_W + IDX_W;
  localparam int DV_SIDE_W = COMP_W + IDX_W;

  logic [RAD_W-1:0]         rad;
  logic signed [PAIR_W-1:0] pair0, pair1, pair2;
  part_t                    part;
  logic [ENTRY_W-1:0]       q_wdata, q_rdata;
  q_status_t                q_stat;
  logic                     push, pop, en;
  logic [RAD_W-1:0]         q_rad;
  logic [2*ROOT_W-1:0]      radicand;
  logic                     sq_valid;
  logic [ROOT_W-1:0]        root;
  logic [SQ_SIDE_W-1:0]     sq_side;
  logic [BQ_W-1:0]          root_ext;
  logic [COMP_W-1:0]        bq;
  logic [N_LANE*COMP_W-1:0] quots;
  logic [DV_SIDE_W-1:0]     dv_side;
  part_t                    out_part;
  logic [COMP_W-1:0]        chosen, q0, q1, q2;
  logic                     chosen_neg;

  r2q_front #(.FRAC_BITS(FRAC_BITS), .RAD_W(RAD_W)) u_front (
    .mat   (s_axis_tdata),
    .rad   (rad),
    .pair0 (pair0),
    .pair1 (pair1),
    .pair2 (pair2),
    .part  (part)
  );

  assign s_axis_tready = !q_stat.full;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_wdata       = {part, pair2, pair1, pair0, rad};

  // the whole back end advances together; hold while a result is not taken
  assign en  = !m_axis_tvalid || m_axis_tready;
  assign pop = en && !q_stat.empty;

  r2q_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (q_wdata),
    .pop    (pop),
    .rdata  (q_rdata),
    .status (q_stat)
  );

  assign q_rad    = q_rdata[RAD_W-1:0];
  assign radicand = (2*ROOT_W)'(q_rad) << (FRAC_BITS - 2);

  r2q_sqrt #(.ROOT_W(ROOT_W), .SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (!q_stat.empty),
    .radicand  (radicand),
    .in_side   (q_rdata[ENTRY_W-1:RAD_W]),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (sq_side)
  );

  assign root_ext = BQ_W'(root);
  assign bq = (root_ext > BQ_W'(16'h7fff)) ? 16'h7fff : root_ext[COMP_W-1:0];

  r2q_div #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W), .SIDE_W(DV_SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .root      (root),
    .pairs     (sq_side[PAIRS_W-1:0]),
    .in_side   ({sq_side[SQ_SIDE_W-1:PAIRS_W], bq}),
    .out_valid (m_axis_tvalid),
    .quots     (quots),
    .out_side  (dv_side)
  );

  assign out_part = part_t'(dv_side[DV_SIDE_W-1:COMP_W]);
  assign chosen   = dv_side[COMP_W-1:0];
  assign q0       = quots[0*COMP_W +: COMP_W];
  assign q1       = quots[1*COMP_W +: COMP_W];
  assign q2       = quots[2*COMP_W +: COMP_W];

  always_comb begin
    unique case (out_part)
      PART_W:  m_axis_tdata = {q2, q1, q0, chosen};
      PART_X:  m_axis_tdata = {q2, q1, chosen, q0};
      PART_Y:  m_axis_tdata = {q2, chosen, q1, q0};
      default: m_axis_tdata = {chosen, q2, q1, q0};
    endcase
  end

  assign m_axis_tuser = out_part;
  assign chosen_neg   = chosen[COMP_W-1];

  `include "rotation_matrix_to_quaternion_unit_defines.svh"

  `R2Q_ASSERT(a_root_nonneg, m_axis_tvalid |-> !chosen_neg, "square-root component negative")

endmodule

[bench/rotation_matrix_to_quaternion_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// Streams rotation matrices into the unit and checks each quaternion and
// chosen-component index against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;
  import r2q_pkg::*;

  localparam int FB        = 14;
  localparam int N_RANDOM  = 1530;
  localparam int CYCLE_MAX = 400000;

  typedef struct packed {
    logic [63:0] quat;
    part_t       part;
  } quat_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         s_axis_tready_seen = 1'b0;

  logic [143:0] matrix_q[$];
  quat_res_t    quat_q[$];
  int           n_sent = 0, n_recv = 0, n_err = 0, cycles = 0;
  int           send_idle = 0, recv_idle = 0, hold_off = 0;
  bit           calm = 1'b0, stim_done = 1'b0, held = 1'b0;

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FB)) dut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0, bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] sat_comp(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pair_quot(longint p, longint unsigned b);
    longint unsigned mag, q;
    mag = (p < 0) ? -p : p;
    if (b == 0) begin
      if (mag == 0) return 16'd0;
      return (p < 0) ? 16'h8000 : 16'h7fff;
    end
    q = (mag << FB) / (b * 4);
    if (q > 65536) q = 65536;
    return sat_comp((p < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_res_t predict_quat(logic [143:0] d);
    longint m[9], t[4], best, r, pwx, pwy, pwz, pxy, pxz, pyz;
    longint unsigned b;
    logic [15:0] bq, w, x, y, z;
    int idx = 0;
    quat_res_t res;
    for (int i = 0; i < 9; i++) m[i] = longint'(signed'(d[16*i +: 16]));
    t[0] = m[0] + m[4] + m[8];
    t[1] = m[0] - m[4] - m[8];
    t[2] = m[4] - m[0] - m[8];
    t[3] = m[8] - m[0] - m[4];
    best = t[0];
    for (int k = 1; k < 4; k++) if (t[k] > best) begin best = t[k]; idx = k; end
    r = best + (64'sd1 << FB);
    if (r < 0) r = 0;
    b = int_sqrt(longint'(r) << (FB - 2));
    bq = sat_comp((b > 32767) ? 32767 : longint'(b));
    pwx = m[5] - m[7]; pwy = m[6] - m[2]; pwz = m[1] - m[3];
    pxy = m[1] + m[3]; pxz = m[6] + m[2]; pyz = m[5] + m[7];
    case (idx)
      0: begin w = bq; x = pair_quot(pwx, b); y = pair_quot(pwy, b); z = pair_quot(pwz, b); end
      1: begin w = pair_quot(pwx, b); x = bq; y = pair_quot(pxy, b); z = pair_quot(pxz, b); end
      2: begin w = pair_quot(pwy, b); x = pair_quot(pxy, b); y = bq; z = pair_quot(pyz, b); end
      default: begin
        w = pair_quot(pwz, b); x = pair_quot(pxz, b); y = pair_quot(pyz, b); z = bq;
      end
    endcase
    res.quat = {z, y, x, w};
    res.part = part_t'(idx[1:0]);
    return res;
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($urandom_range(0, 16384));
      3: return 16'(-$urandom_range(0, 16384));
      default: return 16'($urandom_range(0, 2048) - 1024);
    endcase
  endfunction

  // Mostly near-rotations: a dominant diagonal chosen at random, small off-diagonals.
  function automatic logic [143:0] rand_matrix();
    logic [143:0] d;
    int dom;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 9; i++) d[16*i +: 16] = rand_entry();
      return d;
    end
    dom = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom_range(0, 12000) - 6000);
    for (int k = 0; k < 3; k++)
      d[16*(4*k) +: 16] = (dom == 0 || dom == k + 1) ? 16'($urandom_range(8000, 16384))
                                                       : 16'(-$urandom_range(8000, 16384));
    return d;
  endfunction

  task automatic add_matrix(logic [143:0] d);
    matrix_q.push_back(d);
  endtask

  initial begin
    logic [143:0] d;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    // identity and the three half-turns, one per chosen component
    add_matrix({16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384});
    add_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384});
    add_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384});
    add_matrix({16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384});
    // ties between traces, all zero, all extremes
    add_matrix('0);
    add_matrix({9{16'h7fff}});
    add_matrix({9{16'h8000}});
    add_matrix({9{16'hffff}});
    add_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                16'h8000});
    // negative radicand and out-of-range quotients
    add_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                16'h8000});
    add_matrix({16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                16'h8000});
    add_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                16'h7fff});
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 9; j++) d[16*j +: 16] = rand_entry();
      add_matrix(d);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM * 4 / 5) calm = 1'b1;
      add_matrix(rand_matrix());
      while (matrix_q.size() > 40) @(posedge clk);
    end
    while (matrix_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    stim_done = 1'b1;
  end

  // driver: advance once the offered transfer is taken or nothing is offered
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready_seen) begin
        if (send_idle > 0) begin
          send_idle <= send_idle - 1;
          s_axis_tvalid <= 1'b0;
        end else if (matrix_q.size() != 0) begin
          s_axis_tdata <= matrix_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_idle <= $urandom_range(1, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ready sampled at the last rising edge; the transfer happened there
  always @(posedge clk) begin
    s_axis_tready_seen <= s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      quat_q.push_back(predict_quat(s_axis_tdata));
      n_sent <= n_sent + 1;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (!held && n_sent > 300) begin
      held <= 1'b1;
      hold_off <= 200;
      m_axis_tready <= 1'b0;
    end else if (recv_idle > 0) begin
      recv_idle <= recv_idle - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) recv_idle <= $urandom_range(1, 18);
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_recv <= n_recv + 1;
      if (quat_q.size() == 0) begin
        n_err = n_err + 1;
        if (n_err <= 10) $display("unexpected result: quat %h part %0d", m_axis_tdata,
                                  m_axis_tuser);
      end else begin
        want = quat_q.pop_front();
        if (m_axis_tdata !== want.quat || m_axis_tuser !== want.part) begin
          n_err = n_err + 1;
          if (n_err <= 10)
            $display("mismatch: expected w %h x %h y %h z %h part %0d, got w %h x %h y %h z %h part %0d",
                     want.quat[15:0], want.quat[31:16], want.quat[47:32], want.quat[63:48],
                     want.part, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                     m_axis_tdata[63:48], m_axis_tuser);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (quat_q.size() != 0 && cycles < CYCLE_MAX) @(posedge clk);
    repeat (60) @(posedge clk);
    if (quat_q.size() != 0) n_err = n_err + quat_q.size();
    $display("%0d matrices sent, %0d quaternions checked, all four components chosen",
             n_sent, n_recv);
    if (n_err == 0) $display("rotation_matrix_to_quaternion_unit_tb: done, clean");
    else $display("rotation_matrix_to_quaternion_unit_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_MAX) begin
      $display("rotation_matrix_to_quaternion_unit_tb: done, errors");
      $finish;
    end
  end

endmodule

[rotation_matrix_to_quaternion_unit.f]
+incdir+design
design/r2q_pkg.sv
design/r2q_front.sv
design/r2q_queue.sv
design/r2q_sqrt.sv
design/r2q_div.sv
design/rotation_matrix_to_quaternion_unit.sv
bench/rotation_matrix_to_quaternion_unit_tb.sv
